>>> sv/utf8_message_text_checker_macros.svh
// ---------------------------------------------------------------------------
// UTF-8 message text checker: assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef UTF8_MESSAGE_TEXT_CHECKER_MACROS_SVH
`define UTF8_MESSAGE_TEXT_CHECKER_MACROS_SVH

// same-cycle implication
`define UMTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UMTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/umtc_pkg.sv
// ---------------------------------------------------------------------------
// UTF-8 message text checker: package
// Shared widths, codes, decoder state types and the saturating counter step.
// ---------------------------------------------------------------------------
package umtc_pkg;

    localparam int COUNT_WIDTH     = 17;
    localparam int LIMIT_WIDTH     = 16;
    localparam int POINT_WIDTH     = 21;
    localparam int REASON_WIDTH    = 3;
    localparam int CFG_INDEX_WIDTH = 1;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = COUNT_WIDTH'(1) << (COUNT_WIDTH - 1);

    localparam logic [LIMIT_WIDTH-1:0] MAX_BYTES_RESET = 16'd4096;
    localparam logic [LIMIT_WIDTH-1:0] MAX_CHARS_RESET = 16'd1024;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_TEXT_BYTES = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_TEXT_CHARS = 1'b1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;

    localparam logic [7:0] LEAD_E0 = 8'hE0;
    localparam logic [7:0] LEAD_ED = 8'hED;
    localparam logic [7:0] LEAD_F0 = 8'hF0;
    localparam logic [7:0] LEAD_F4 = 8'hF4;

    typedef enum logic [REASON_WIDTH-1:0] {
        REASON_OK         = 3'd0,
        REASON_EMPTY      = 3'd1,
        REASON_MANY_BYTES = 3'd2,
        REASON_MALFORMED  = 3'd3,
        REASON_MANY_CHARS = 3'd4,
        REASON_CONTROL    = 3'd5
    } t_reason;

    typedef struct packed {
        logic [1:0]             cont_left;
        logic [7:0]             lead;
        logic                   first_cont;
        logic [POINT_WIDTH-1:0] partial;
    } t_dec_state;

    typedef struct packed {
        t_dec_state nxt;
        logic       point_done;
        logic       control;
        logic       malformed;
    } t_dec_result;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] byte_total;
        logic [COUNT_WIDTH-1:0] char_total;
        logic                   malformed;
        logic                   control;
        logic                   open_seq;
    } t_msg_status;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v < COUNT_MAX) ? v + COUNT_WIDTH'(1) : COUNT_MAX;
    endfunction

endpackage

>>> sv/umtc_decode.sv
// ---------------------------------------------------------------------------
// UTF-8 message text checker: byte decoder
// Strict UTF-8 step for one byte: next sequence state, completed code point,
// control character and malformation flags.
// ---------------------------------------------------------------------------
module umtc_decode
    import umtc_pkg::*;
(
    input  t_dec_state  i_state,
    input  logic [7:0]  i_byte,
    output t_dec_result o_result
);

    t_dec_state             lead_st;
    logic                   lead_done;
    logic                   lead_mal;
    logic                   cont_ok;
    logic [POINT_WIDTH-1:0] shifted;
    logic [POINT_WIDTH-1:0] cp;
    logic                   done;
    logic                   is_ctrl;
    t_dec_state             nxt_st;
    logic                   dec_mal;

    always_comb begin
        lead_st            = i_state;
        lead_st.cont_left  = 2'd0;
        lead_st.first_cont = 1'b0;
        lead_done          = 1'b0;
        lead_mal           = 1'b0;
        if (!i_byte[7]) begin
            if (i_byte == CHAR_NUL) begin
                lead_mal = 1'b1;
            end else begin
                lead_done = 1'b1;
            end
        end else if (i_byte >= 8'hC2 && i_byte <= 8'hDF) begin
            lead_st.cont_left  = 2'd1;
            lead_st.partial    = POINT_WIDTH'(i_byte[4:0]);
            lead_st.lead       = i_byte;
            lead_st.first_cont = 1'b1;
        end else if (i_byte >= 8'hE0 && i_byte <= 8'hEF) begin
            lead_st.cont_left  = 2'd2;
            lead_st.partial    = POINT_WIDTH'(i_byte[3:0]);
            lead_st.lead       = i_byte;
            lead_st.first_cont = 1'b1;
        end else if (i_byte >= 8'hF0 && i_byte <= 8'hF4) begin
            lead_st.cont_left  = 2'd3;
            lead_st.partial    = POINT_WIDTH'(i_byte[2:0]);
            lead_st.lead       = i_byte;
            lead_st.first_cont = 1'b1;
        end else begin
            lead_mal = 1'b1;
        end
    end

    always_comb begin
        cont_ok = (i_byte[7:6] == 2'b10);
        if (i_state.first_cont) begin
            case (i_state.lead)
                LEAD_E0: cont_ok = cont_ok && (i_byte >= 8'hA0);
                LEAD_ED: cont_ok = cont_ok && (i_byte <= 8'h9F);
                LEAD_F0: cont_ok = cont_ok && (i_byte >= 8'h90);
                LEAD_F4: cont_ok = cont_ok && (i_byte <= 8'h8F);
                default: ;
            endcase
        end
    end

    assign shifted = {i_state.partial[POINT_WIDTH-7:0], i_byte[5:0]};

    always_comb begin
        if (i_state.cont_left != 2'd0 && cont_ok) begin
            nxt_st            = i_state;
            nxt_st.partial    = shifted;
            nxt_st.cont_left  = i_state.cont_left - 2'd1;
            nxt_st.first_cont = 1'b0;
            done              = (i_state.cont_left == 2'd1);
            cp                = shifted;
            dec_mal           = 1'b0;
        end else begin
            // no open sequence, or a broken one: drop it and take the byte as a lead
            nxt_st  = lead_st;
            done    = lead_done;
            cp      = POINT_WIDTH'(i_byte);
            dec_mal = lead_mal || (i_state.cont_left != 2'd0);
        end
    end

    assign is_ctrl = ((cp >= POINT_WIDTH'(8'h01) && cp <= POINT_WIDTH'(8'h1F)) ||
                      (cp >= POINT_WIDTH'(8'h7F) && cp <= POINT_WIDTH'(8'h9F))) &&
                     cp != POINT_WIDTH'(CHAR_TAB) && cp != POINT_WIDTH'(CHAR_LF) &&
                     cp != POINT_WIDTH'(CHAR_CR);

    assign o_result = {nxt_st, done, done && is_ctrl, dec_mal};

endmodule

>>> sv/umtc_verdict.sv
// ---------------------------------------------------------------------------
// UTF-8 message text checker: verdict
// Picks the first failing check of a finished message.
// ---------------------------------------------------------------------------
module umtc_verdict
    import umtc_pkg::*;
(
    input  t_msg_status            i_status,
    input  logic [LIMIT_WIDTH-1:0] i_max_bytes,
    input  logic [LIMIT_WIDTH-1:0] i_max_chars,
    output t_reason                o_reason
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

    logic [CMP_WIDTH-1:0] bytes_ext;
    logic [CMP_WIDTH-1:0] chars_ext;
    logic [CMP_WIDTH-1:0] max_bytes_ext;
    logic [CMP_WIDTH-1:0] max_chars_ext;

    assign bytes_ext     = CMP_WIDTH'(i_status.byte_total);
    assign chars_ext     = CMP_WIDTH'(i_status.char_total);
    assign max_bytes_ext = CMP_WIDTH'(i_max_bytes);
    assign max_chars_ext = CMP_WIDTH'(i_max_chars);

    always_comb begin
        if (i_status.byte_total == '0) begin
            o_reason = REASON_EMPTY;
        end else if (bytes_ext > max_bytes_ext) begin
            o_reason = REASON_MANY_BYTES;
        end else if (i_status.malformed || i_status.open_seq) begin
            o_reason = REASON_MALFORMED;
        end else if (chars_ext > max_chars_ext) begin
            o_reason = REASON_MANY_CHARS;
        end else if (i_status.control) begin
            o_reason = REASON_CONTROL;
        end else begin
            o_reason = REASON_OK;
        end
    end

endmodule

>>> sv/utf8_message_text_checker.sv
// ---------------------------------------------------------------------------
// UTF-8 message text checker: top level
// Strict UTF-8 check, byte and code point counts and limits per message.
// ---------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): one request per cycle unless
// stalled, a text byte (i_kind = 0) or the end of a message (i_kind = 1).
// Output channel (o_out_valid / i_out_stall): one verdict request per end
// item, with the reason code and the saturated byte and code point counts.
// Requests are registered on entry; bytes are decoded in the next cycle
// against the sequence state; one request per cycle while not stalled.
// An end item is judged from the input register once the output register
// is free, and its verdict is loaded into the output register.
// A stalled verdict holds in the output register; the next end item then
// waits in the input register and o_in_stall rises, while text bytes keep
// flowing until that point.
// Synchronous reset clears the message state and both channels and loads
// the limits with 4096 bytes and 1024 code points. Limits are written on
// i_cfg_we, index 0 for bytes and 1 for code points.
// ---------------------------------------------------------------------------
module utf8_message_text_checker
    import umtc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_kind,
    input  logic [7:0]                 i_text_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_text_ok,
    output logic [REASON_WIDTH-1:0]    o_reject_reason,
    output logic [COUNT_WIDTH-1:0]     o_bytes_seen,
    output logic [COUNT_WIDTH-1:0]     o_chars_seen,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [LIMIT_WIDTH-1:0]     i_cfg_data
);

    logic                   r_in_valid;
    logic                   r_in_kind;
    logic [7:0]             r_in_byte;
    t_dec_state             r_dec;
    logic [COUNT_WIDTH-1:0] r_byte_total;
    logic [COUNT_WIDTH-1:0] r_char_total;
    logic                   r_malformed;
    logic                   r_control;
    logic [LIMIT_WIDTH-1:0] r_max_bytes;
    logic [LIMIT_WIDTH-1:0] r_max_chars;
    logic                   r_out_valid;
    logic                   r_text_ok;
    t_reason                r_reason;
    logic [COUNT_WIDTH-1:0] r_bytes;
    logic [COUNT_WIDTH-1:0] r_chars;

    logic                   out_free;
    logic                   proceed;
    logic                   in_accept;
    logic                   byte_fire;
    logic                   end_fire;
    t_dec_result            dec;
    t_msg_status            status;
    t_reason                reason;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proceed    = r_in_valid && (r_in_kind == KIND_BYTE || out_free);
    assign o_in_stall = r_in_valid && !proceed;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign byte_fire  = proceed && r_in_kind == KIND_BYTE;
    assign end_fire   = proceed && r_in_kind == KIND_END;

    umtc_decode u_decode (
        .i_state  (r_dec),
        .i_byte   (r_in_byte),
        .o_result (dec)
    );

    assign status.byte_total = r_byte_total;
    assign status.char_total = r_char_total;
    assign status.malformed  = r_malformed;
    assign status.control    = r_control;
    assign status.open_seq   = (r_dec.cont_left != 2'd0);

    umtc_verdict u_verdict (
        .i_status    (status),
        .i_max_bytes (r_max_bytes),
        .i_max_chars (r_max_chars),
        .o_reason    (reason)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_text_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= MAX_BYTES_RESET;
            r_max_chars <= MAX_CHARS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_TEXT_BYTES: r_max_bytes <= i_cfg_data;
                CFG_MAX_TEXT_CHARS: r_max_chars <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || end_fire) begin
            r_dec        <= '0;
            r_byte_total <= '0;
            r_char_total <= '0;
            r_malformed  <= 1'b0;
            r_control    <= 1'b0;
        end else if (byte_fire) begin
            r_dec        <= dec.nxt;
            r_byte_total <= sat_inc(r_byte_total);
            if (dec.point_done) begin
                r_char_total <= sat_inc(r_char_total);
            end
            r_malformed  <= r_malformed || dec.malformed;
            r_control    <= r_control || dec.control;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (end_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (end_fire) begin
            r_text_ok <= (reason == REASON_OK);
            r_reason  <= reason;
            r_bytes   <= r_byte_total;
            r_chars   <= r_char_total;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_text_ok       = r_text_ok;
    assign o_reject_reason = r_reason;
    assign o_bytes_seen    = r_bytes;
    assign o_chars_seen    = r_chars;

endmodule

>>> sv/umtc_checker.sv
// ---------------------------------------------------------------------------
// UTF-8 message text checker: port checker
// Watches the verdict channel of the top level.
// ---------------------------------------------------------------------------
`include "utf8_message_text_checker_macros.svh"

module umtc_checker
    import umtc_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic                    o_text_ok,
    input logic [REASON_WIDTH-1:0] o_reject_reason,
    input logic [COUNT_WIDTH-1:0]  o_bytes_seen,
    input logic [COUNT_WIDTH-1:0]  o_chars_seen
);

    `UMTC_ASSERT_NOW(a_ok_matches_reason, o_out_valid, o_text_ok == (o_reject_reason == REASON_OK), "text_ok disagrees with reject_reason")
    `UMTC_ASSERT_NOW(a_empty_iff_no_bytes, o_out_valid, (o_reject_reason == REASON_EMPTY) == (o_bytes_seen == '0), "empty verdict disagrees with byte count")
    `UMTC_ASSERT_NOW(a_chars_within_bytes, o_out_valid, o_chars_seen <= o_bytes_seen, "more code points than bytes")
    `UMTC_ASSERT_NEXT(a_hold_stalled, o_out_valid && i_out_stall, o_out_valid && $stable(o_reject_reason) && $stable(o_bytes_seen) && $stable(o_chars_seen), "stalled verdict changed")

endmodule

bind utf8_message_text_checker umtc_checker u_umtc_checker (.*);

>>> bench/utf8_message_text_checker_test.sv
// ---------------------------------------------------------------------------
// UTF-8 message text checker: testbench
// Sends message text byte by byte and closes each message with an end
// request. A scoreboard decodes the same stream, predicts each verdict and
// checks it against the output channel. The run covers hand-picked
// messages, random well-formed, broken and noisy messages under several
// limit settings, and one long message under the widest limits.
// The input idles and the output stalls at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_message_text_checker_test;
    import umtc_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_LIMIT  = 1000;
    localparam int LONG_TEXT    = 200;

    typedef struct packed {
        logic                   ok;
        t_reason                reason;
        logic [COUNT_WIDTH-1:0] bytes;
        logic [COUNT_WIDTH-1:0] chars;
    } t_verdict;

    class text_verdict_board;
        logic [LIMIT_WIDTH-1:0] byte_limit;
        logic [LIMIT_WIDTH-1:0] char_limit;
        logic [COUNT_WIDTH-1:0] byte_count;
        logic [COUNT_WIDTH-1:0] point_count;
        logic [1:0]             tail_left;
        logic [7:0]             lead_byte;
        logic                   first_tail;
        logic [POINT_WIDTH-1:0] point_acc;
        logic                   bad_text;
        logic                   saw_control;
        t_verdict               pending_verdicts[$];
        int                     mismatches;

        function new();
            byte_limit = MAX_BYTES_RESET;
            char_limit = MAX_CHARS_RESET;
            mismatches = 0;
            clear_text();
        endfunction

        function void clear_text();
            byte_count  = '0;
            point_count = '0;
            tail_left   = '0;
            lead_byte   = '0;
            first_tail  = 1'b0;
            point_acc   = '0;
            bad_text    = 1'b0;
            saw_control = 1'b0;
        endfunction

        function void set_limit(logic [CFG_INDEX_WIDTH-1:0] idx, logic [LIMIT_WIDTH-1:0] value);
            if (idx == CFG_MAX_TEXT_BYTES) begin
                byte_limit = value;
            end else if (idx == CFG_MAX_TEXT_CHARS) begin
                char_limit = value;
            end
        endfunction

        function logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] v);
            return v[COUNT_WIDTH-1] ? v : v + 1'b1;
        endfunction

        function void close_point(logic [POINT_WIDTH-1:0] cp);
            point_count = bump(point_count);
            if (((cp >= 'h01 && cp <= 'h1F) || (cp >= 'h7F && cp <= 'h9F)) &&
                cp != CHAR_TAB && cp != CHAR_LF && cp != CHAR_CR) begin
                saw_control = 1'b1;
            end
        endfunction

        function bit tail_fits(logic [7:0] b);
            if (b[7:6] != 2'b10) return 1'b0;
            if (!first_tail) return 1'b1;
            case (lead_byte)
                LEAD_E0: return b >= 8'hA0;
                LEAD_ED: return b <= 8'h9F;
                LEAD_F0: return b >= 8'h90;
                LEAD_F4: return b <= 8'h8F;
                default: return 1'b1;
            endcase
        endfunction

        function void start_point(logic [7:0] b);
            tail_left = '0;
            if (!b[7]) begin
                if (b == CHAR_NUL) bad_text = 1'b1;
                else close_point(POINT_WIDTH'(b));
                return;
            end
            if (b >= 8'hC2 && b <= 8'hDF) begin
                tail_left = 2'd1;
                point_acc = POINT_WIDTH'(b[4:0]);
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
                tail_left = 2'd2;
                point_acc = POINT_WIDTH'(b[3:0]);
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
                tail_left = 2'd3;
                point_acc = POINT_WIDTH'(b[2:0]);
            end else begin
                bad_text = 1'b1;
                return;
            end
            lead_byte  = b;
            first_tail = 1'b1;
        endfunction

        function void note_request(logic kind, logic [7:0] b);
            t_verdict v;
            t_reason  why;
            if (kind == KIND_BYTE) begin
                byte_count = bump(byte_count);
                if (tail_left != 0) begin
                    if (tail_fits(b)) begin
                        point_acc  = {point_acc[POINT_WIDTH-7:0], b[5:0]};
                        tail_left  = tail_left - 1'b1;
                        first_tail = 1'b0;
                        if (tail_left == 0) close_point(point_acc);
                    end else begin
                        bad_text   = 1'b1;
                        tail_left  = '0;
                        first_tail = 1'b0;
                        start_point(b);
                    end
                end else begin
                    start_point(b);
                end
                return;
            end
            if (tail_left != 0) bad_text = 1'b1;
            if (byte_count == 0) why = REASON_EMPTY;
            else if (byte_count > {1'b0, byte_limit}) why = REASON_MANY_BYTES;
            else if (bad_text) why = REASON_MALFORMED;
            else if (point_count > {1'b0, char_limit}) why = REASON_MANY_CHARS;
            else if (saw_control) why = REASON_CONTROL;
            else why = REASON_OK;
            v.ok     = (why == REASON_OK);
            v.reason = why;
            v.bytes  = byte_count;
            v.chars  = point_count;
            pending_verdicts.push_back(v);
            clear_text();
        endfunction

        function void flag(string field, logic [COUNT_WIDTH-1:0] want, logic [COUNT_WIDTH-1:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        endfunction

        function void check_verdict(logic ok, logic [REASON_WIDTH-1:0] reason,
                                    logic [COUNT_WIDTH-1:0] bytes, logic [COUNT_WIDTH-1:0] chars);
            t_verdict want;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("verdict with none outstanding: reason %0d, bytes %0d", reason, bytes);
                return;
            end
            want = pending_verdicts.pop_front();
            if (ok !== want.ok)
                flag("text_ok", COUNT_WIDTH'(want.ok), COUNT_WIDTH'(ok));
            if (reason !== want.reason)
                flag("reject_reason", COUNT_WIDTH'(want.reason), COUNT_WIDTH'(reason));
            if (bytes !== want.bytes) flag("bytes_seen", want.bytes, bytes);
            if (chars !== want.chars) flag("chars_seen", want.chars, chars);
        endfunction

        function void close_out();
            if (pending_verdicts.size() != 0) begin
                mismatches += pending_verdicts.size();
                $display("%0d verdicts never arrived", pending_verdicts.size());
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_kind = KIND_BYTE;
    logic [7:0]                 i_text_byte = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic                       o_text_ok;
    logic [REASON_WIDTH-1:0]    o_reject_reason;
    logic [COUNT_WIDTH-1:0]     o_bytes_seen;
    logic [COUNT_WIDTH-1:0]     o_chars_seen;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [LIMIT_WIDTH-1:0]     i_cfg_data = '0;

    text_verdict_board board = new();
    logic [7:0]        msg_text[$];
    int                items_sent = 0;
    int                burst_left = 0;
    int                quiet_cycles = 0;
    int                stall_run = 0;
    logic              stall_now = 1'b0;

    utf8_message_text_checker u_dut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_verdict(o_text_ok, o_reject_reason, o_bytes_seen, o_chars_seen);
        if (stall_run == 0) begin
            stall_now = !stall_now && ($urandom_range(0, 3) != 0);
            if (stall_now) stall_run = $urandom_range(1, 12);
            else if ($urandom_range(0, 9) == 0) stall_run = $urandom_range(100, 300);
            else stall_run = $urandom_range(1, 20);
        end else begin
            stall_run--;
        end
        i_out_stall <= stall_now;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic kind, input logic [7:0] b);
        int gap;
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_text_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_request(kind, b);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                      : $urandom_range(0, 16);
        end
    endtask

    task automatic drain_verdicts();
        i_in_valid <= 1'b0;
        while (board.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_limits(input logic [LIMIT_WIDTH-1:0] byte_max,
                                input logic [LIMIT_WIDTH-1:0] char_max);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAX_TEXT_BYTES;
        i_cfg_data  <= byte_max;
        @(posedge i_clk);
        board.set_limit(CFG_MAX_TEXT_BYTES, byte_max);
        i_cfg_index <= CFG_MAX_TEXT_CHARS;
        i_cfg_data  <= char_max;
        @(posedge i_clk);
        board.set_limit(CFG_MAX_TEXT_CHARS, char_max);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_message_text();
        foreach (msg_text[i]) send_request(KIND_BYTE, msg_text[i]);
        send_request(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [POINT_WIDTH-1:0] pick_point();
        int                     r;
        logic [POINT_WIDTH-1:0] cp;
        r = $urandom_range(0, 99);
        if (r < 50) return POINT_WIDTH'($urandom_range('h20, 'h7E));
        if (r < 53) begin
            case ($urandom_range(0, 2))
                0: return POINT_WIDTH'(CHAR_TAB);
                1: return POINT_WIDTH'(CHAR_LF);
                default: return POINT_WIDTH'(CHAR_CR);
            endcase
        end
        if (r < 55) return POINT_WIDTH'($urandom_range(0, 1) ? $urandom_range('h01, 'h1F)
                                                             : $urandom_range('h7F, 'h9F));
        if (r < 62) begin
            case ($urandom_range(0, 9))
                0: return 'h80;
                1: return 'h7FF;
                2: return 'h800;
                3: return 'hD7FF;
                4: return 'hE000;
                5: return 'hFFFF;
                6: return 'h10000;
                7: return 'h10FFFF;
                8: return 'h7E;
                default: return 'hA0;
            endcase
        end
        if (r < 75) return POINT_WIDTH'($urandom_range('hA0, 'h7FF));
        if (r < 90) begin
            cp = POINT_WIDTH'($urandom_range('h800, 'hFFFF));
            if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 'h1000;
            return cp;
        end
        return POINT_WIDTH'($urandom_range('h10000, 'h10FFFF));
    endfunction

    function automatic void push_point(logic [POINT_WIDTH-1:0] cp);
        if (cp < 'h80) begin
            msg_text.push_back(cp[7:0]);
        end else if (cp < 'h800) begin
            msg_text.push_back({3'b110, cp[10:6]});
            msg_text.push_back({2'b10, cp[5:0]});
        end else if (cp < 'h10000) begin
            msg_text.push_back({4'b1110, cp[15:12]});
            msg_text.push_back({2'b10, cp[11:6]});
            msg_text.push_back({2'b10, cp[5:0]});
        end else begin
            msg_text.push_back({5'b11110, cp[20:18]});
            msg_text.push_back({2'b10, cp[17:12]});
            msg_text.push_back({2'b10, cp[11:6]});
            msg_text.push_back({2'b10, cp[5:0]});
        end
    endfunction

    function automatic logic [7:0] tail_byte();
        return 8'($urandom_range('h80, 'hBF));
    endfunction

    function automatic void push_defect();
        int                     start_len;
        int                     span;
        logic [POINT_WIDTH-1:0] cp;
        case ($urandom_range(0, 7))
            0: msg_text.push_back(CHAR_NUL);
            1: msg_text.push_back($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hC1))
                                                      : 8'($urandom_range('hF5, 'hFF)));
            2: begin
                case ($urandom_range(0, 2))
                    0: msg_text.push_back(8'($urandom_range('hC0, 'hC1)));
                    1: begin
                        msg_text.push_back(LEAD_E0);
                        msg_text.push_back(8'($urandom_range('h80, 'h9F)));
                    end
                    default: begin
                        msg_text.push_back(LEAD_F0);
                        msg_text.push_back(8'($urandom_range('h80, 'h8F)));
                        msg_text.push_back(tail_byte());
                    end
                endcase
                msg_text.push_back(tail_byte());
            end
            3: begin
                msg_text.push_back(LEAD_ED);
                msg_text.push_back(8'($urandom_range('hA0, 'hBF)));
                msg_text.push_back(tail_byte());
            end
            4: begin
                msg_text.push_back(LEAD_F4);
                msg_text.push_back(8'($urandom_range('h90, 'hBF)));
                msg_text.push_back(tail_byte());
                msg_text.push_back(tail_byte());
            end
            5: begin
                case ($urandom_range(0, 2))
                    0: cp = POINT_WIDTH'($urandom_range('h80, 'h7FF));
                    1: cp = POINT_WIDTH'($urandom_range('h800, 'hD7FF));
                    default: cp = POINT_WIDTH'($urandom_range('h10000, 'h10FFFF));
                endcase
                start_len = msg_text.size();
                push_point(cp);
                span = msg_text.size() - start_len;
                repeat ($urandom_range(1, span - 1)) void'(msg_text.pop_back());
            end
            6: msg_text.push_back(tail_byte());
            default: msg_text.push_back(8'($urandom_range(0, 255)));
        endcase
    endfunction

    function automatic void build_message();
        int flavour;
        int n;
        int spot;
        msg_text.delete();
        flavour = $urandom_range(0, 99);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 200) : $urandom_range(0, 16);
        if (flavour >= 90) begin
            repeat (n + 1) msg_text.push_back(8'($urandom_range(0, 255)));
            return;
        end
        spot = (flavour < 70) ? -1 : $urandom_range(0, n);
        for (int i = 0; i <= n; i++) begin
            if (i == spot) push_defect();
            if (i < n) push_point(pick_point());
        end
        if (flavour >= 85) push_defect();
    endfunction

    initial begin : stimulus
        int phase;
        int target;
        int phase_end;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty, plain, control, zero, broken, truncated, bad lead, top of range
        msg_text = '{};
        send_message_text();
        msg_text = '{CHAR_TAB, CHAR_LF, CHAR_CR, 8'h41};
        send_message_text();
        msg_text = '{8'hC2, 8'h80};
        send_message_text();
        msg_text = '{CHAR_NUL};
        send_message_text();
        msg_text = '{LEAD_E0, 8'h9F, 8'hBF};
        send_message_text();
        msg_text = '{LEAD_F0};
        send_message_text();
        msg_text = '{8'hFF};
        send_message_text();
        msg_text = '{LEAD_F4, 8'h8F, 8'hBF, 8'hBF};
        send_message_text();

        phase  = 0;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            drain_verdicts();
            case (phase)
                0: write_limits(16'hFFFF, 16'hFFFF);
                1: write_limits(16'h0000, 16'($urandom_range(1, 65535)));
                2: write_limits(16'hFFFF, 16'h0000);
                3: write_limits(16'h0001, 16'h0001);
                default: begin
                    case ($urandom_range(0, 4))
                        0, 1: write_limits(16'($urandom_range(8, 96)), 16'($urandom_range(2, 32)));
                        2: write_limits(MAX_BYTES_RESET, MAX_CHARS_RESET);
                        3: write_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                        default: write_limits(16'($urandom_range(1, 24)), 16'($urandom_range(1, 12)));
                    endcase
                end
            endcase
            phase_end = items_sent + ((phase < 4) ? 40 : $urandom_range(80, 200));
            while (items_sent < phase_end) begin
                build_message();
                send_message_text();
            end
            phase++;
        end

        // one long message under the widest limits
        drain_verdicts();
        write_limits(16'hFFFF, 16'hFFFF);
        repeat (LONG_TEXT) send_request(KIND_BYTE, 8'($urandom_range('h20, 'h7E)));
        send_request(KIND_END, 8'($urandom_range(0, 255)));

        drain_verdicts();
        repeat (4) @(posedge i_clk);
        board.close_out();
        if (board.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/umtc_pkg.sv
sv/umtc_decode.sv
sv/umtc_verdict.sv
sv/utf8_message_text_checker.sv
sv/umtc_checker.sv
bench/utf8_message_text_checker_test.sv
